// ----- hdl/ppc_pkg.sv -----
// Shared types, widths and register indexes for the particle/plane collision block.
// No dependencies; imported by every module of the block.
package ppc_pkg;

    localparam int WORD_W        = 32;
    localparam int NORM_W        = 18;
    localparam int MARGIN_W      = 31;
    localparam int IDX_W         = 3;
    localparam int FRAC_BITS_DEF = 16;

    // Full-precision widths of the height and normal-velocity terms
    localparam int DIFF_W  = WORD_W + 1;
    localparam int DPROD_W = DIFF_W + NORM_W;
    localparam int HSUM_W  = DPROD_W + 2;
    localparam int VPROD_W = WORD_W + NORM_W;
    localparam int VSUM_W  = VPROD_W + 2;

    typedef logic signed [WORD_W-1:0] ppc_word_t;
    typedef logic signed [NORM_W-1:0] ppc_norm_t;
    typedef logic [IDX_W-1:0]         ppc_idx_t;

    localparam ppc_idx_t REG_ORIGIN_X = 3'd0;
    localparam ppc_idx_t REG_ORIGIN_Y = 3'd1;
    localparam ppc_idx_t REG_ORIGIN_Z = 3'd2;
    localparam ppc_idx_t REG_NORMAL_X = 3'd3;
    localparam ppc_idx_t REG_NORMAL_Y = 3'd4;
    localparam ppc_idx_t REG_NORMAL_Z = 3'd5;
    localparam ppc_idx_t REG_MARGIN   = 3'd6;
    localparam ppc_idx_t REG_ENABLE   = 3'd7;

    localparam ppc_norm_t NORMAL_Y_RST = 18'sd65536;

    typedef struct packed {
        ppc_word_t [2:0] pos;
        ppc_word_t [2:0] vel;
    } ppc_particle_t;

    typedef struct packed {
        ppc_word_t [2:0]     origin;
        ppc_norm_t [2:0]     normal;
        logic [MARGIN_W-1:0] margin;
        logic                enable;
    } ppc_cfg_t;

endpackage

// ----- hdl/ppc_height.sv -----
// Front half of the pipeline: signed plane height and normal velocity, three stages.
// Depends on ppc_pkg.
module ppc_height
    import ppc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ppc_particle_t                         in_item,
    input  ppc_cfg_t                              cfg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ppc_particle_t                         out_item,
    output logic signed [HSUM_W-FRAC_BITS-1:0]    out_h,
    output logic signed [VSUM_W-FRAC_BITS-1:0]    out_cosv,
    output logic                                  out_vn_nonpos
);

    localparam int HW = HSUM_W - FRAC_BITS;
    localparam int CW = VSUM_W - FRAC_BITS;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    ppc_particle_t s1_item_reg, s2_item_reg, s3_item_reg;

    logic signed [DIFF_W-1:0]  s1_diff_next  [3];
    logic signed [DIFF_W-1:0]  s1_diff_reg   [3];
    logic signed [VPROD_W-1:0] s1_vprod_next [3];
    logic signed [VPROD_W-1:0] s1_vprod_reg  [3];

    logic signed [DPROD_W-1:0] s2_dprod_next [3];
    logic signed [DPROD_W-1:0] s2_dprod_reg  [3];
    logic signed [VSUM_W-1:0]  s2_vsum_next;
    logic signed [VSUM_W-1:0]  s2_vsum_reg;

    logic signed [HSUM_W-1:0]  s3_hsum;
    logic signed [HW-1:0]      s3_h_next, s3_h_reg;
    logic signed [CW-1:0]      s3_cosv_next, s3_cosv_reg;
    logic                      s3_nonpos_next, s3_nonpos_reg;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: offset from plane origin, normal times velocity
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_diff_next[i]  = DIFF_W'(in_item.pos[i]) - DIFF_W'(cfg.origin[i]);
            s1_vprod_next[i] = cfg.normal[i] * in_item.vel[i];
        end
    end

    // stage 2: normal times offset, normal velocity sum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s2_dprod_next[i] = cfg.normal[i] * s1_diff_reg[i];
        s2_vsum_next = VSUM_W'(s1_vprod_reg[0]) + VSUM_W'(s1_vprod_reg[1])
                     + VSUM_W'(s1_vprod_reg[2]);
    end

    // stage 3: height sum, scale back (floor shift)
    always_comb
    begin
        s3_hsum = HSUM_W'(s2_dprod_reg[0]) + HSUM_W'(s2_dprod_reg[1])
                + HSUM_W'(s2_dprod_reg[2]);
        s3_h_next      = s3_hsum[HSUM_W-1:FRAC_BITS];
        s3_cosv_next   = s2_vsum_reg[VSUM_W-1:FRAC_BITS];
        s3_nonpos_next = s2_vsum_reg[VSUM_W-1] || (s2_vsum_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_item_reg <= in_item;
            for (int i = 0; i < 3; i++)
            begin
                s1_diff_reg[i]  <= s1_diff_next[i];
                s1_vprod_reg[i] <= s1_vprod_next[i];
            end
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg <= s1_item_reg;
            s2_vsum_reg <= s2_vsum_next;
            for (int i = 0; i < 3; i++)
                s2_dprod_reg[i] <= s2_dprod_next[i];
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_item_reg   <= s2_item_reg;
            s3_h_reg      <= s3_h_next;
            s3_cosv_reg   <= s3_cosv_next;
            s3_nonpos_reg <= s3_nonpos_next;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign out_item      = s3_item_reg;
    assign out_h         = s3_h_reg;
    assign out_cosv      = s3_cosv_reg;
    assign out_vn_nonpos = s3_nonpos_reg;

endmodule

// ----- hdl/ppc_response.sv -----
// Back half of the pipeline: projection onto the plane, push-out, velocity
// reflection and output saturation, four stages. Depends on ppc_pkg.
module ppc_response
    import ppc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ppc_particle_t                         in_item,
    input  logic signed [HSUM_W-FRAC_BITS-1:0]    in_h,
    input  logic signed [VSUM_W-FRAC_BITS-1:0]    in_cosv,
    input  logic                                  in_vn_nonpos,
    input  ppc_cfg_t                              cfg,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ppc_particle_t                         out_item,
    output logic                                  out_bounced
);

    localparam int HW    = HSUM_W - FRAC_BITS;
    localparam int CW    = VSUM_W - FRAC_BITS;
    localparam int CORRW = NORM_W + HW;
    localparam int CSW   = CORRW - FRAC_BITS;
    localparam int P1W   = ((CSW > WORD_W) ? CSW : WORD_W) + 1;
    localparam int CFW   = FRAC_BITS + 2;
    localparam int KPW   = CFW + CW;
    localparam int KW    = KPW - FRAC_BITS;
    localparam int PSW   = ((HW > WORD_W) ? HW : WORD_W) + 1;
    localparam int PPW   = NORM_W + PSW;
    localparam int PPSW  = PPW - FRAC_BITS;
    localparam int KNW   = NORM_W + KW;
    localparam int KNSW  = KNW - FRAC_BITS;
    localparam int P2W   = ((PPSW > P1W) ? PPSW : P1W) + 1;
    localparam int V2W   = ((KNSW > WORD_W) ? KNSW : WORD_W) + 1;

    // restitution 0.8 -> subtract 1.8 x normal part
    localparam logic signed [CFW-1:0] COEF = CFW'(((18 << FRAC_BITS) + 5) / 10);

    localparam ppc_word_t SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam ppc_word_t SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg;
    logic r1_ready, r2_ready, r3_ready, r4_ready;

    // stage 1
    ppc_particle_t             r1_item_reg;
    logic signed [CORRW-1:0]   r1_corr_next [3];
    logic signed [CORRW-1:0]   r1_corr_reg  [3];
    logic signed [KPW-1:0]     r1_kp_next, r1_kp_reg;
    logic signed [HW-1:0]      r1_hc;
    logic signed [PSW-1:0]     r1_push_next, r1_push_reg;
    logic                      r1_hneg_next, r1_hneg_reg;
    logic                      r1_bounce_next, r1_bounce_reg;

    // stage 2
    ppc_word_t [2:0]           r2_vel_reg;
    logic signed [P1W-1:0]     r2_p1_next [3];
    logic signed [P1W-1:0]     r2_p1_reg  [3];
    logic signed [P1W-1:0]     r2_corr_s;
    logic signed [KW-1:0]      r2_k_next, r2_k_reg;
    logic signed [PSW-1:0]     r2_push_reg;
    logic                      r2_bounce_reg;

    // stage 3
    ppc_word_t [2:0]           r3_vel_reg;
    logic signed [P1W-1:0]     r3_p1_reg  [3];
    logic signed [PPW-1:0]     r3_pp_next [3];
    logic signed [PPW-1:0]     r3_pp_reg  [3];
    logic signed [KNW-1:0]     r3_kn_next [3];
    logic signed [KNW-1:0]     r3_kn_reg  [3];
    logic                      r3_bounce_reg;

    // stage 4 (output)
    logic signed [P2W-1:0]     r4_pp_s;
    logic signed [P2W-1:0]     r4_p2;
    logic signed [V2W-1:0]     r4_kn_s;
    logic signed [V2W-1:0]     r4_v2;
    ppc_particle_t             r4_item_next, r4_item_reg;
    logic                      r4_bounced_reg;

    assign r4_ready = !r4_valid_reg || out_ready;
    assign r3_ready = !r3_valid_reg || r4_ready;
    assign r2_ready = !r2_valid_reg || r3_ready;
    assign r1_ready = !r1_valid_reg || r2_ready;
    assign in_ready = r1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end
        else
        begin
            if (r1_ready)
                r1_valid_reg <= in_valid;
            if (r2_ready)
                r2_valid_reg <= r1_valid_reg;
            if (r3_ready)
                r3_valid_reg <= r2_valid_reg;
            if (r4_ready)
                r4_valid_reg <= r3_valid_reg;
        end
    end

    // stage 1: clamp height at zero, contact test, projection and 1.8 products
    always_comb
    begin
        r1_hneg_next = cfg.enable && in_h[HW-1];
        r1_hc        = in_h[HW-1] ? '0 : in_h;
        for (int i = 0; i < 3; i++)
            r1_corr_next[i] = cfg.normal[i] * in_h;
        r1_kp_next   = COEF * in_cosv;
        r1_push_next = PSW'($signed({1'b0, cfg.margin})) - PSW'(r1_hc);
        // push > 0 is the same as clamped height below margin
        r1_bounce_next = cfg.enable && in_vn_nonpos && !r1_push_next[PSW-1]
                       && (r1_push_next != '0);
    end

    // stage 2: move onto plane when below it, scale the reflection factor
    always_comb
    begin
        r2_corr_s = '0;
        for (int i = 0; i < 3; i++)
        begin
            r2_corr_s = r1_hneg_reg ? P1W'($signed(r1_corr_reg[i][CORRW-1:FRAC_BITS])) : '0;
            r2_p1_next[i] = P1W'(r1_item_reg.pos[i]) - r2_corr_s;
        end
        r2_k_next = $signed(r1_kp_reg[KPW-1:FRAC_BITS]);
    end

    // stage 3: push-out and reflection products along the normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r3_pp_next[i] = cfg.normal[i] * r2_push_reg;
            r3_kn_next[i] = cfg.normal[i] * r2_k_reg;
        end
    end

    // stage 4: apply and saturate to 32 bits
    always_comb
    begin
        r4_pp_s      = '0;
        r4_p2        = '0;
        r4_kn_s      = '0;
        r4_v2        = '0;
        r4_item_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            r4_pp_s = r3_bounce_reg ? P2W'($signed(r3_pp_reg[i][PPW-1:FRAC_BITS])) : '0;
            r4_p2   = P2W'(r3_p1_reg[i]) + r4_pp_s;
            r4_kn_s = r3_bounce_reg ? V2W'($signed(r3_kn_reg[i][KNW-1:FRAC_BITS])) : '0;
            r4_v2   = V2W'(r3_vel_reg[i]) - r4_kn_s;

            if (r4_p2[P2W-1:WORD_W-1] == '0 || r4_p2[P2W-1:WORD_W-1] == '1)
                r4_item_next.pos[i] = r4_p2[WORD_W-1:0];
            else
                r4_item_next.pos[i] = r4_p2[P2W-1] ? SAT_MIN : SAT_MAX;

            if (r4_v2[V2W-1:WORD_W-1] == '0 || r4_v2[V2W-1:WORD_W-1] == '1)
                r4_item_next.vel[i] = r4_v2[WORD_W-1:0];
            else
                r4_item_next.vel[i] = r4_v2[V2W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1_ready)
        begin
            r1_item_reg   <= in_item;
            r1_kp_reg     <= r1_kp_next;
            r1_push_reg   <= r1_push_next;
            r1_hneg_reg   <= r1_hneg_next;
            r1_bounce_reg <= r1_bounce_next;
            for (int i = 0; i < 3; i++)
                r1_corr_reg[i] <= r1_corr_next[i];
        end
        if (r1_valid_reg && r2_ready)
        begin
            r2_vel_reg    <= r1_item_reg.vel;
            r2_k_reg      <= r2_k_next;
            r2_push_reg   <= r1_push_reg;
            r2_bounce_reg <= r1_bounce_reg;
            for (int i = 0; i < 3; i++)
                r2_p1_reg[i] <= r2_p1_next[i];
        end
        if (r2_valid_reg && r3_ready)
        begin
            r3_vel_reg    <= r2_vel_reg;
            r3_bounce_reg <= r2_bounce_reg;
            for (int i = 0; i < 3; i++)
            begin
                r3_p1_reg[i] <= r2_p1_reg[i];
                r3_pp_reg[i] <= r3_pp_next[i];
                r3_kn_reg[i] <= r3_kn_next[i];
            end
        end
        if (r3_valid_reg && r4_ready)
        begin
            r4_item_reg    <= r4_item_next;
            r4_bounced_reg <= r3_bounce_reg;
        end
    end

    assign out_valid   = r4_valid_reg;
    assign out_item    = r4_item_reg;
    assign out_bounced = r4_bounced_reg;

endmodule

// ----- hdl/particle_plane_collision_top.sv -----
// Particle/plane collision response. Throughput: one beat per cycle while out_stall is low;
// each of the seven stages holds one item and moves whenever the stage after it is free, so a
// stall on the output fills the stages in turn.
// Reset: pipeline empties, configuration returns to origin 0, normal (0, 1.0, 0),
// margin 0, block disabled.
// Contains config registers; instantiates ppc_height and ppc_response, uses ppc_pkg.
module particle_plane_collision_top
    import ppc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_we,
    input  ppc_idx_t          cfg_idx,
    input  logic [WORD_W-1:0] cfg_wdata,

    input  logic              in_valid,
    output logic              in_stall,
    input  ppc_word_t         pos_x,
    input  ppc_word_t         pos_y,
    input  ppc_word_t         pos_z,
    input  ppc_word_t         vel_x,
    input  ppc_word_t         vel_y,
    input  ppc_word_t         vel_z,

    output logic              out_valid,
    input  logic              out_stall,
    output ppc_word_t         new_pos_x,
    output ppc_word_t         new_pos_y,
    output ppc_word_t         new_pos_z,
    output ppc_word_t         new_vel_x,
    output ppc_word_t         new_vel_y,
    output ppc_word_t         new_vel_z,
    output logic              bounced
);

    localparam int HW = HSUM_W - FRAC_BITS;
    localparam int CW = VSUM_W - FRAC_BITS;

    // origin 0, normal (0, 1.0, 0), margin 0, disabled
    localparam ppc_cfg_t CFG_RST = ppc_cfg_t'({{(3*WORD_W){1'b0}}, {NORM_W{1'b0}},
                                               NORMAL_Y_RST, {NORM_W{1'b0}},
                                               {MARGIN_W{1'b0}}, 1'b0});

    ppc_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_X: cfg_next.origin[0] = cfg_wdata;
                REG_ORIGIN_Y: cfg_next.origin[1] = cfg_wdata;
                REG_ORIGIN_Z: cfg_next.origin[2] = cfg_wdata;
                REG_NORMAL_X: cfg_next.normal[0] = cfg_wdata[NORM_W-1:0];
                REG_NORMAL_Y: cfg_next.normal[1] = cfg_wdata[NORM_W-1:0];
                REG_NORMAL_Z: cfg_next.normal[2] = cfg_wdata[NORM_W-1:0];
                REG_MARGIN:   cfg_next.margin    = cfg_wdata[MARGIN_W-1:0];
                REG_ENABLE:   cfg_next.enable    = cfg_wdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ppc_particle_t        in_item;
    ppc_particle_t        mid_item;
    ppc_particle_t        out_item;
    logic                 in_ready;
    logic                 mid_valid;
    logic                 mid_ready;
    logic signed [HW-1:0] mid_h;
    logic signed [CW-1:0] mid_cosv;
    logic                 mid_vn_nonpos;

    assign in_item.pos[0] = pos_x;
    assign in_item.pos[1] = pos_y;
    assign in_item.pos[2] = pos_z;
    assign in_item.vel[0] = vel_x;
    assign in_item.vel[1] = vel_y;
    assign in_item.vel[2] = vel_z;

    ppc_height #(
        .FRAC_BITS (FRAC_BITS)
    ) u_height (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .cfg           (cfg_reg),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_item      (mid_item),
        .out_h         (mid_h),
        .out_cosv      (mid_cosv),
        .out_vn_nonpos (mid_vn_nonpos)
    );

    ppc_response #(
        .FRAC_BITS (FRAC_BITS)
    ) u_response (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .in_item      (mid_item),
        .in_h         (mid_h),
        .in_cosv      (mid_cosv),
        .in_vn_nonpos (mid_vn_nonpos),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .out_ready    (!out_stall),
        .out_item     (out_item),
        .out_bounced  (bounced)
    );

    assign in_stall  = !in_ready;

    assign new_pos_x = out_item.pos[0];
    assign new_pos_y = out_item.pos[1];
    assign new_pos_z = out_item.pos[2];
    assign new_vel_x = out_item.vel[0];
    assign new_vel_y = out_item.vel[1];
    assign new_vel_z = out_item.vel[2];

endmodule
